// File: src/wcup_pkg.sv
// Package for the wide-character unsigned integer parser.
// Holds the parse phase codes, character constants and the digit decoder.
// No dependencies.
package wcup_pkg;

    localparam int CHAR_W = 21;
    localparam int BASE_W = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;
    localparam int OFFSET_W = 16;

    typedef logic [2:0] phase_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [BASE_W-1:0] base_t;

    // Parse phase codes
    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_SPACE  = 3'd1;
    localparam phase_t PH_SIGNED = 3'd2;
    localparam phase_t PH_ZERO   = 3'd3;
    localparam phase_t PH_DIGITS = 3'd4;
    localparam phase_t PH_DONE   = 3'd5;

    // Digit progress codes
    localparam logic [1:0] DS_NONE = 2'd0;
    localparam logic [1:0] DS_SOME = 2'd1;
    localparam logic [1:0] DS_OVF  = 2'd2;

    // Character codes
    localparam char_t CH_TAB   = 21'd9;
    localparam char_t CH_CR    = 21'd13;
    localparam char_t CH_SPACE = 21'd32;
    localparam char_t CH_PLUS  = 21'd43;
    localparam char_t CH_MINUS = 21'd45;
    localparam char_t CH_ZERO  = 21'd48;
    localparam char_t CH_NINE  = 21'd57;
    localparam char_t CH_UA    = 21'd65;
    localparam char_t CH_UZ    = 21'd90;
    localparam char_t CH_LA    = 21'd97;
    localparam char_t CH_LZ    = 21'd122;
    localparam char_t CH_UX    = 21'd88;
    localparam char_t CH_LX    = 21'd120;

    // Radix limits
    localparam base_t BASE_MIN  = 6'd2;
    localparam base_t BASE_MAX  = 6'd36;
    localparam base_t BASE_ONE  = 6'd1;
    localparam base_t BASE_AUTO = 6'd0;
    localparam base_t BASE_OCT  = 6'd8;
    localparam base_t BASE_DEC  = 6'd10;
    localparam base_t BASE_HEX  = 6'd16;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } digit_t;

    // Alphanumeric decode: 0-9, then A-Z / a-z as 10..35
    function automatic digit_t digit_of(input char_t c);
        digit_t d;
        char_t  t;
        d.valid = 1'b0;
        d.value = '0;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            t = c - CH_ZERO;
            d.valid = 1'b1;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            t = c - (CH_UA - 21'd10);
            d.valid = 1'b1;
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            t = c - (CH_LA - 21'd10);
            d.valid = 1'b1;
        end
        d.value = t[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

// File: src/wide_char_to_unsigned_parser.sv
// Streaming wide-string to unsigned 64-bit integer parser, top level.
// Words pass through an input register, a combinational parse step and a result register.
// One word per cycle unless a result that is not yet taken stalls the parse; the digit step
// is one 64x6 multiply-add with carry-out overflow check.
// Reset (async, active low) clears parse state to idle and the base register to 10.
// Depends on wcup_pkg.
module wide_char_to_unsigned_parser
    import wcup_pkg::*;
#(
    parameter longint unsigned MAX_OFFSET = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: number_base
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] char_code, [23:21] zero
    input  logic        s_axis_tuser,   // [0] first_char
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] value, [79:64] end_offset
    output logic [1:0]  m_axis_tuser    // [0] range_error, [1] bad_base
);

    localparam int CNT_W = $clog2(MAX_OFFSET + 64'd1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OFFSET);
    localparam int PROD_W = VALUE_W + BASE_W;

    // Registers
    base_t              base_reg;
    logic               in_valid_reg;
    char_t              in_char_reg;
    logic               in_first_reg;
    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               minus_reg, minus_next;
    logic [1:0]         dstat_reg, dstat_next;
    base_t              wbase_reg, wbase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic               out_range_reg;
    logic               out_bad_reg;

    // Per-word results
    logic               emit;
    logic [VALUE_W-1:0] res_value;
    logic [OFFSET_W-1:0] res_offset;
    logic               res_range;
    logic               res_bad;
    logic               fire;

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_DEC;
        else if (cfg_valid)
            base_reg <= cfg_data;
    end

    // Parse step: one character against the current state
    always_comb
    begin
        logic               active;
        logic               do_after;
        logic               do_digit;
        base_t              b;
        digit_t             dg;
        logic [PROD_W-1:0]  prod;
        logic [63:0]        cnt_wide;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        dstat_next = dstat_reg;
        wbase_next = wbase_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        res_value  = '0;
        res_offset = '0;
        res_range  = 1'b0;
        res_bad    = 1'b0;
        active     = 1'b1;
        do_after   = 1'b0;
        do_digit   = 1'b0;
        b          = BASE_DEC;
        prod       = '0;
        dg         = digit_of(in_char_reg);
        cnt_wide   = 64'(cnt_reg);

        // new string restarts the parse
        if (in_first_reg)
        begin
            acc_next   = '0;
            minus_next = 1'b0;
            dstat_next = DS_NONE;
            cnt_next   = '0;
            cnt_wide   = '0;
            wbase_next = base_reg;
            phase_next = PH_SPACE;
            if (base_reg == BASE_ONE || base_reg > BASE_MAX)
            begin
                emit       = 1'b1;
                res_bad    = 1'b1;
                phase_next = PH_DONE;
                active     = 1'b0;
            end
        end

        if (active)
        begin
            unique case (phase_next)
                PH_SPACE:
                begin
                    if (in_char_reg == CH_SPACE ||
                        (in_char_reg >= CH_TAB && in_char_reg <= CH_CR))
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (in_char_reg == CH_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (in_char_reg == CH_PLUS)
                        phase_next = PH_SIGNED;
                    else
                        do_after = 1'b1;
                end
                PH_SIGNED:
                    do_after = 1'b1;
                PH_ZERO:
                begin
                    if (in_char_reg == CH_LX || in_char_reg == CH_UX)
                    begin
                        wbase_next = BASE_HEX;
                        dstat_next = DS_NONE;
                        acc_next   = '0;
                        phase_next = PH_DIGITS;
                    end
                    else
                        do_digit = 1'b1;
                end
                PH_DIGITS:
                    do_digit = 1'b1;
                default:
                    active = 1'b0;
            endcase
        end

        // character after whitespace or sign: leading zero check
        if (do_after)
        begin
            if ((wbase_next == BASE_AUTO || wbase_next == BASE_HEX) &&
                in_char_reg == CH_ZERO)
            begin
                acc_next   = '0;
                dstat_next = DS_SOME;
                wbase_next = (wbase_next == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                phase_next = PH_ZERO;
            end
            else
            begin
                if (wbase_next == BASE_AUTO)
                    wbase_next = BASE_DEC;
                do_digit = 1'b1;
            end
        end

        // digit accumulate or stop
        if (do_digit)
        begin
            b = (wbase_next < BASE_MIN || wbase_next > BASE_MAX) ? BASE_DEC : wbase_next;
            if (!(dg.valid && dg.value < b))
            begin
                emit       = 1'b1;
                res_offset = (dstat_next != DS_NONE) ? cnt_wide[OFFSET_W-1:0] : '0;
                res_range  = (dstat_next == DS_OVF);
                if (dstat_next == DS_OVF)
                    res_value = '1;
                else if (minus_next)
                    res_value = VALUE_W'(0) - acc_next;
                else
                    res_value = acc_next;
                phase_next = PH_DONE;
            end
            else
            begin
                prod = PROD_W'(acc_next) * PROD_W'(b) + PROD_W'(dg.value);
                if (dstat_next == DS_OVF || prod[PROD_W-1:VALUE_W] != '0)
                    dstat_next = DS_OVF;
                else
                begin
                    dstat_next = DS_SOME;
                    acc_next   = prod[VALUE_W-1:0];
                end
                phase_next = PH_DIGITS;
            end
        end

        // saturating character count
        if (active && cnt_next < CNT_MAX)
            cnt_next = cnt_next + CNT_W'(1);
    end

    // Handshake: the parse stage advances unless a result would overwrite a held one
    assign fire = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg  <= s_axis_tdata[CHAR_W-1:0];
            in_first_reg <= s_axis_tuser;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            dstat_reg <= DS_NONE;
            wbase_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            dstat_reg <= dstat_next;
            wbase_reg <= wbase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_value_reg  <= res_value;
            out_offset_reg <= res_offset;
            out_range_reg  <= res_range;
            out_bad_reg    <= res_bad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_offset_reg, out_value_reg};
    assign m_axis_tuser  = {out_bad_reg, out_range_reg};

    // Checks
    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[63:0] == '0 && !m_axis_tuser[0] && m_axis_tdata[79:64] == '0)
        else $error("bad base result carries nonzero fields");

    a_range_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] == '1)
        else $error("range error result is not all ones");

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> phase_reg == PH_DONE)
        else $error("parser did not stop after giving a result");

endmodule

// File: test/tb_wide_char_to_unsigned_parser.sv
// Testbench for wide_char_to_unsigned_parser: streams wide strings and checks every parsed
// number against an in-bench model of the parse, under several radix settings and stall mixes.
// Depends on wcup_pkg and the parser top level.
module tb_wide_char_to_unsigned_parser;
    import wcup_pkg::*;

    localparam longint unsigned MAX_OFFSET = 65535;
    localparam int unsigned NOT_DIGIT = 99;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PRINT_CAP = 40;
    localparam int PHASES = 10;
    localparam int unsigned LONG_RUN = 100;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        range_error;
        logic        bad_base;
    } parse_result_t;

    typedef struct {
        char_t code;
        logic  first;
    } wide_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [20:0] char_code, [23:21] zero
    logic        s_axis_tuser = 1'b0;   // [0] first_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // [63:0] value, [79:64] end_offset
    logic [1:0]  m_axis_tuser;          // [0] range_error, [1] bad_base

    wide_char_to_unsigned_parser #(.MAX_OFFSET(MAX_OFFSET)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Words waiting to be sent, and parsed numbers waiting to come out
    wide_char_t    char_stream[$];
    parse_result_t parsed_numbers[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned words_queued = 0;
    logic        string_open = 1'b0;
    base_t       cur_base = BASE_DEC;

    // Parser model state
    base_t       base_reg = BASE_DEC;
    phase_t      scan_phase = PH_IDLE;
    logic [63:0] scan_acc = '0;
    logic        scan_minus = 1'b0;
    logic [1:0]  scan_digits = DS_NONE;
    base_t       scan_radix = BASE_AUTO;
    int unsigned scan_count = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------
    function automatic logic [63:0] char_value(char_t c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 64'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ)
            return 64'(c - CH_UA) + 64'd10;
        if (c >= CH_LA && c <= CH_LZ)
            return 64'(c - CH_LA) + 64'd10;
        return 64'(NOT_DIGIT);
    endfunction

    function automatic void digit_step(char_t c);
        logic [63:0]   radix;
        logic [63:0]   d;
        logic [63:0]   cutoff;
        logic [63:0]   cutlim;
        parse_result_t r;
        radix = 64'(scan_radix);
        if (radix < 64'(BASE_MIN) || radix > 64'(BASE_MAX))
            radix = 64'(BASE_DEC);
        d = char_value(c);
        if (d >= radix)
        begin
            // stop character: emit the number
            r.end_offset = (scan_digits != DS_NONE) ? scan_count[15:0] : 16'd0;
            r.range_error = (scan_digits == DS_OVF);
            r.bad_base = 1'b0;
            if (scan_digits == DS_OVF)
                r.value = ALL_ONES;
            else
                r.value = scan_minus ? (64'd0 - scan_acc) : scan_acc;
            parsed_numbers.push_back(r);
            scan_phase = PH_DONE;
            return;
        end
        cutoff = ALL_ONES / radix;
        cutlim = ALL_ONES % radix;
        if (scan_digits == DS_OVF || scan_acc > cutoff || (scan_acc == cutoff && d > cutlim))
            scan_digits = DS_OVF;
        else
        begin
            scan_digits = DS_SOME;
            scan_acc = scan_acc * radix + d;
        end
        scan_phase = PH_DIGITS;
    endfunction

    // First character after whitespace or sign: a leading zero may open a prefix
    function automatic void lead_step(char_t c);
        if ((scan_radix == BASE_AUTO || scan_radix == BASE_HEX) && c == CH_ZERO)
        begin
            scan_acc = '0;
            scan_digits = DS_SOME;
            scan_radix = (scan_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            scan_phase = PH_ZERO;
            return;
        end
        if (scan_radix == BASE_AUTO)
            scan_radix = BASE_DEC;
        digit_step(c);
    endfunction

    function automatic void parse_char(char_t c, logic first);
        if (first)
        begin
            scan_acc = '0;
            scan_minus = 1'b0;
            scan_digits = DS_NONE;
            scan_count = 0;
            scan_radix = base_reg;
            if (scan_radix == BASE_ONE || scan_radix > BASE_MAX)
            begin
                parsed_numbers.push_back('{value: '0, end_offset: '0, range_error: 1'b0,
                                           bad_base: 1'b1});
                scan_phase = PH_DONE;
                return;
            end
            scan_phase = PH_SPACE;
        end
        unique case (scan_phase)
            PH_SPACE:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    ;
                else if (c == CH_MINUS)
                begin
                    scan_minus = 1'b1;
                    scan_phase = PH_SIGNED;
                end
                else if (c == CH_PLUS)
                    scan_phase = PH_SIGNED;
                else
                    lead_step(c);
            end
            PH_SIGNED:
                lead_step(c);
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    scan_radix = BASE_HEX;
                    scan_digits = DS_NONE;
                    scan_acc = '0;
                    scan_phase = PH_DIGITS;
                end
                else
                    digit_step(c);
            end
            PH_DIGITS:
                digit_step(c);
            default:
                return;
        endcase
        if (64'(scan_count) < MAX_OFFSET)
            scan_count++;
    endfunction

    // ---------------------------------------------------------------
    // Input driver: presents queued words, random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                char_stream.delete(0);
            if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, char_stream[0].code};
                s_axis_tuser <= char_stream[0].first;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result side ready: random stalls, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: check results, then track config and input words
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        parse_result_t seen;
        parse_result_t want;
        if (!rst_n)
        begin
            base_reg = BASE_DEC;
            scan_phase = PH_IDLE;
            scan_acc = '0;
            scan_minus = 1'b0;
            scan_digits = DS_NONE;
            scan_radix = BASE_AUTO;
            scan_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = {m_axis_tdata[63:0], m_axis_tdata[79:64], m_axis_tuser[0], m_axis_tuser[1]};
                if (parsed_numbers.size() == 0)
                    report("unexpected word value", seen.value, '0);
                else
                begin
                    want = parsed_numbers.pop_front();
                    if (seen.value !== want.value)
                        report("value", seen.value, want.value);
                    if (seen.end_offset !== want.end_offset)
                        report("end_offset", 64'(seen.end_offset), 64'(want.end_offset));
                    if (seen.range_error !== want.range_error)
                        report("range_error", 64'(seen.range_error), 64'(want.range_error));
                    if (seen.bad_base !== want.bad_base)
                        report("bad_base", 64'(seen.bad_base), 64'(want.bad_base));
                end
            end
            if (cfg_valid && cfg_ready)
                base_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                parse_char(s_axis_tdata[20:0], s_axis_tuser);
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_raw(char_t c, logic first);
        char_stream.push_back('{code: c, first: first});
        words_queued++;
    endtask

    // next word of the current string; the first one carries first_char
    task automatic push_char(char_t c);
        push_raw(c, string_open);
        string_open = 1'b0;
    endtask

    task automatic push_text(string s);
        string_open = 1'b1;
        for (int i = 0; i < s.len(); i++)
            push_char(char_t'(s[i]));
    endtask

    function automatic char_t digit_char(int unsigned d);
        if (d < 10)
            return CH_ZERO + char_t'(d);
        return ($urandom_range(1) ? CH_UA : CH_LA) + char_t'(d - 10);
    endfunction

    task automatic push_number(logic [63:0] v, base_t radix);
        int unsigned digs[$];
        do
        begin
            digs.push_front(32'(v % 64'(radix)));
            v = v / 64'(radix);
        end
        while (v != 0);
        foreach (digs[i])
            push_char(digit_char(digs[i]));
    endtask

    function automatic char_t space_char();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + char_t'(r);
    endfunction

    // One string: whitespace, sign, prefix, digits, stop word, maybe stray words
    task automatic push_random_string();
        int unsigned r;
        int unsigned n;
        base_t       radix;
        string_open = 1'b1;
        if ($urandom_range(9) == 0)
        begin
            // noise: random words with random string starts
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                push_raw(char_t'($urandom_range(0, 1114111)), 1'($urandom_range(1)));
            return;
        end
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                push_char(space_char());
        end
        r = $urandom_range(9);
        if (r < 3)
            push_char(CH_MINUS);
        else if (r == 3)
            push_char(CH_PLUS);
        radix = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
        if (cur_base == BASE_AUTO || cur_base == BASE_HEX)
        begin
            r = $urandom_range(3);
            if (r == 0)
            begin
                push_char(CH_ZERO);
                push_char($urandom_range(1) ? CH_LX : CH_UX);
                radix = BASE_HEX;
            end
            else if (r == 1)
            begin
                push_char(CH_ZERO);
                if (cur_base == BASE_AUTO)
                    radix = BASE_OCT;
            end
        end
        if (radix < BASE_MIN || radix > BASE_MAX)
            radix = BASE_DEC;
        r = $urandom_range(11);
        if (r < 5)
            push_number(64'($urandom_range(0, 999)), radix);
        else if (r < 7)
            push_number({$urandom, $urandom}, radix);
        else if (r == 7)
            push_number(ALL_ONES, radix);
        else if (r == 8)
        begin
            // one digit short of the top, then a digit on either side of the cut
            push_number(ALL_ONES / 64'(radix), radix);
            push_char(digit_char($urandom_range(0, 32'(radix) - 1)));
        end
        else if (r == 9)
        begin
            push_number(ALL_ONES, radix);
            push_char(digit_char($urandom_range(0, 32'(radix) - 1)));
        end
        // r above 9: no digits at all
        if ($urandom_range(1))
            push_char(char_t'($urandom_range(33, 47)));
        else
            push_char(char_t'($urandom_range(0, 1114111)));
        if ($urandom_range(4) == 0)
        begin
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++)
                push_raw(char_t'($urandom_range(0, 1114111)), 1'b0);
        end
    endtask

    task automatic fill_strings(int unsigned budget);
        int unsigned start;
        start = words_queued;
        while (words_queued - start < budget)
            push_random_string();
    endtask

    // Wait until every queued word went in and every number came out
    task automatic drain();
        while (char_stream.size() != 0 || s_axis_tvalid || parsed_numbers.size() != 0)
            @(negedge clk);
    endtask

    // Register write, only with the parser idle
    task automatic write_base(base_t v);
        drain();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = v;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        base_t       setting;
        int unsigned budget;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: radix 10 from reset
        push_raw(CH_LX, 1'b0);              // stray word before any string
        push_raw('0, 1'b1);                 // lowest code, no digits
        push_text(" \t-12z");
        push_raw(21'h10FFFF, 1'b1);         // highest code, no digits
        push_raw(CH_UA, 1'b0);              // stray word after the result
        // automatic radix: bare prefix, octal, hex
        write_base(BASE_AUTO);
        push_text("0x!");
        push_text("017:");
        push_text("0XfF ");
        // invalid radix, rest of the string ignored
        write_base(BASE_ONE);
        push_text("5");
        push_raw(CH_ZERO, 1'b0);

        // random phases over radix settings and stall mixes
        for (int p = 0; p < PHASES; p++)
        begin
            unique case (p)
                0: setting = BASE_DEC;
                1: setting = BASE_AUTO;
                2: setting = BASE_HEX;
                3: setting = BASE_MAX;
                4: setting = BASE_MIN;
                5: setting = BASE_OCT;
                6: setting = BASE_ONE;
                7: setting = '1;
                8: setting = BASE_MAX + 6'd1;
                default: setting = base_t'($urandom_range(0, 36));
            endcase
            write_base(setting);
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            budget = (setting == BASE_ONE || setting > BASE_MAX) ? 40 : 140;
            // long result-side hold-off while words keep coming
            if (p == 0)
                holds_asked++;
            fill_strings(budget / 2);
            drain();
            fill_strings(budget - budget / 2);
        end

        // one long string of leading zeros
        write_base(BASE_DEC);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        string_open = 1'b1;
        push_char(CH_MINUS);
        for (int unsigned k = 0; k < LONG_RUN; k++)
            push_char(CH_ZERO);
        push_char(CH_ZERO + 21'd5);
        push_char(CH_PLUS);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
